[rtl/core/csif_pkg.sv]
// ----------------------------------------------------------------------------
// csif_pkg
// Shared types, constants and helpers of the coastal snow/ice fill unit.
// ----------------------------------------------------------------------------
`default_nettype none

package csif_pkg;

  // Line store geometry
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned HGT_W      = 13;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  // Class codes
  localparam logic [7:0] CODE_COAST  = 8'd252;
  localparam logic [7:0] CODE_FILLED = 8'd200;
  localparam logic [7:0] CODE_ICE_A  = 8'd103;
  localparam logic [7:0] CODE_ICE_B  = 8'd104;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  // Request kinds carried on the input tuser
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  // Snow or ice class test
  function automatic logic is_snow(input logic [7:0] code);
    is_snow = (code == CODE_ICE_A) || (code == CODE_ICE_B) || (code == CODE_FILLED) ||
              (code inside {[8'd26:8'd101]});
  endfunction

  // Clamp a written width into 1..MAX_WIDTH
  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] val);
    logic [10:0] w;
    w = val[10:0];
    if (w == 11'd0) begin
      clamp_width = WID_W'(1);
    end else if (w > 11'(MAX_WIDTH)) begin
      clamp_width = WID_W'(MAX_WIDTH);
    end else begin
      clamp_width = WID_W'(w);
    end
  endfunction

  // Clamp a written height into 1..MAX_HEIGHT
  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] val);
    if (val == '0) begin
      clamp_height = HGT_W'(1);
    end else if (val > CFG_DATA_W'(MAX_HEIGHT)) begin
      clamp_height = HGT_W'(MAX_HEIGHT);
    end else begin
      clamp_height = HGT_W'(val);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/coastal_snow_ice_fill_unit.sv]
// ----------------------------------------------------------------------------
// coastal_snow_ice_fill_unit
// Fills coast pixels next to snow or ice in a raster class map, one row late.
// ----------------------------------------------------------------------------
//  channel   dir  tdata         tuser        tlast
//  s_axis    in   pixel_in[7:0] req_type     -
//  m_axis    out  pixel_out     was_filled   frame_last
//  cfg       in   write enable, register index, write data (no read-back)
//
//  One item per cycle while the skid is free; each beat is worked out in the cycle
//  it is taken, from two registered line-store reads fetched on the previous beat,
//  and lands in the output register. A two-deep output register/skid pair lets
//  input continue for one beat while the output stalls. No clearing pass after
//  reset: line stores are read only where the current frame wrote them.
// ----------------------------------------------------------------------------
`default_nettype none

module coastal_snow_ice_fill_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                           s_axis_tuser,   // [0] req_type
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] pixel_out
  output logic                                m_axis_tuser,   // [0] was_filled
  output logic                                m_axis_tlast,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [csif_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [csif_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned COL_W = csif_pkg::COL_W;
  localparam int unsigned WID_W = csif_pkg::WID_W;
  localparam int unsigned ROW_W = csif_pkg::ROW_W;
  localparam int unsigned HGT_W = csif_pkg::HGT_W;

  // Line stores
  logic [7:0] mid_mem [csif_pkg::MAX_WIDTH];
  logic [7:0] up_mem  [csif_pkg::MAX_WIDTH];

  // Configuration and position state
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             drain_q;
  logic [7:0]       left_q;
  logic [7:0]       cen_q;
  logic [7:0]       first_q;
  logic [7:0]       mid_rd_q;
  logic [7:0]       up_rd_q;

  // Output register and skid
  logic             out_v_q;
  logic [9:0]       out_q;
  logic             skid_v_q;
  logic [9:0]       skid_q;

  logic             accept;
  logic             is_pixel;
  logic             pix_step;
  logic             drain_step;
  logic             step;
  logic             emit;
  logic             col_last;
  logic             row_last;
  logic [COL_W-1:0] next_col;
  logic [COL_W-1:0] mid_rd_addr;
  logic             has_up;
  logic             has_left;
  logic             snow;
  logic             filled;
  logic [7:0]       res;
  logic [9:0]       res_beat;
  logic             out_take;

  assign s_axis_tready = !skid_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_pixel      = (csif_pkg::req_type_e'(s_axis_tuser) == csif_pkg::REQ_PIXEL);
  assign pix_step      = accept && is_pixel && !drain_q;
  assign drain_step    = accept && !is_pixel && drain_q;
  assign step          = pix_step || drain_step;
  assign emit          = drain_step || (pix_step && (row_q != '0));

  // Raster position of this beat
  assign col_last    = ({1'b0, col_q} == (width_q - WID_W'(1)));
  assign row_last    = ({1'b0, row_q} == (height_q - HGT_W'(1)));
  assign next_col    = col_last ? '0 : (col_q + COL_W'(1));
  assign mid_rd_addr = next_col + COL_W'(1);

  // Neighbour test and fill decision
  assign has_up   = drain_q ? (row_q != '0) : (row_q > ROW_W'(1));
  assign has_left = (col_q != '0);
  assign snow     = (has_up && csif_pkg::is_snow(up_rd_q)) ||
                    (has_left && csif_pkg::is_snow(left_q)) ||
                    (!col_last && csif_pkg::is_snow(mid_rd_q)) ||
                    (!drain_q && csif_pkg::is_snow(s_axis_tdata));
  assign filled   = (cen_q == csif_pkg::CODE_COAST) && snow;
  assign res      = filled ? csif_pkg::CODE_FILLED : cen_q;
  assign res_beat = {drain_q && col_last, filled, res};

  // Middle line: write the raw pixel, fetch the right neighbour of the next beat
  always_ff @(posedge clk_i) begin
    if (pix_step) begin
      mid_mem[col_q] <= s_axis_tdata;
    end
    if (step) begin
      if (pix_step && (mid_rd_addr == col_q)) begin
        mid_rd_q <= s_axis_tdata;
      end else begin
        mid_rd_q <= mid_mem[mid_rd_addr];
      end
    end
  end

  // Upper line: write the processed pixel, fetch the up neighbour of the next beat
  always_ff @(posedge clk_i) begin
    if (emit) begin
      up_mem[col_q] <= res;
    end
    if (step) begin
      if (emit && (next_col == col_q)) begin
        up_rd_q <= res;
      end else begin
        up_rd_q <= up_mem[next_col];
      end
    end
  end

  // Centre pipeline and first pixel of the row being input
  always_ff @(posedge clk_i) begin
    if (pix_step && (col_q == '0)) begin
      first_q <= s_axis_tdata;
    end
    if (step) begin
      if (!col_last) begin
        cen_q <= mid_rd_q;
      end else if (col_q == '0) begin
        cen_q <= s_axis_tdata;
      end else begin
        cen_q <= first_q;
      end
    end
  end

  // Configuration, counters and drain phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(csif_pkg::MAX_WIDTH);
      height_q <= HGT_W'(1024);
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= 1'b0;
      left_q   <= '0;
    end else if (cfg_we_i) begin
      case (csif_pkg::reg_idx_e'(cfg_idx_i))
        csif_pkg::REG_GRID_WIDTH:  width_q  <= csif_pkg::clamp_width(cfg_wdata_i);
        csif_pkg::REG_GRID_HEIGHT: height_q <= csif_pkg::clamp_height(cfg_wdata_i);
        default: ;
      endcase
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= 1'b0;
      left_q  <= '0;
    end else if (step) begin
      col_q <= next_col;
      if (drain_step && col_last) begin
        // end of frame: restart the stream
        row_q   <= '0;
        drain_q <= 1'b0;
        left_q  <= '0;
      end else begin
        if (emit) begin
          left_q <= res;
        end
        if (pix_step && col_last) begin
          if (row_last) begin
            drain_q <= 1'b1;
          end else begin
            row_q <= row_q + ROW_W'(1);
          end
        end
      end
    end
  end

  // Output register with one skid entry
  assign out_take = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (emit) begin
      if (!out_v_q || out_take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (emit) begin
      if (!out_v_q || out_take) begin
        out_q <= res_beat;
      end else begin
        skid_q <= res_beat;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q[7:0];
  assign m_axis_tuser  = out_q[8];
  assign m_axis_tlast  = out_q[9];

endmodule

`default_nettype wire

[dv/tb_coastal_snow_ice_fill_unit.sv]
// ----------------------------------------------------------------------------
// tb_coastal_snow_ice_fill_unit
// Self-checking bench for the coast fill unit: drives raster pixel and drain
// beats under varied grid settings and back-pressure, predicts every output
// beat in a scoreboard and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_coastal_snow_ice_fill_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_BEATS  = 540;
  localparam int unsigned WIDE_BEATS    = 64;

  typedef struct packed {
    logic [7:0] code;
    logic       filled;
    logic       last;
  } out_beat_t;

  // Predicts the processed map one row behind the input, as the unit does
  class fill_scoreboard;
    bit [10:0]   grid_w;
    bit [12:0]   grid_h;
    bit [7:0]    upper_row [csif_pkg::MAX_WIDTH];
    bit [7:0]    middle_row [csif_pkg::MAX_WIDTH];
    bit [7:0]    left_px;
    int unsigned in_row, in_col, out_row, out_col;
    bit          draining;
    out_beat_t   expected_q [$];
    int unsigned errors = 0;
    int unsigned pixel_beats = 0, drain_beats = 0, ignored_beats = 0;
    int unsigned out_beats = 0, fills = 0, frames = 0, settings = 0;

    function new();
      grid_w = 11'd1024;
      grid_h = 13'd1024;
      restart();
    endfunction

    function int unsigned grid_cols();
      if (grid_w == 0) return 1;
      if (grid_w > csif_pkg::MAX_WIDTH) return csif_pkg::MAX_WIDTH;
      return grid_w;
    endfunction

    function int unsigned grid_rows();
      if (grid_h == 0) return 1;
      if (grid_h > csif_pkg::MAX_HEIGHT) return csif_pkg::MAX_HEIGHT;
      return grid_h;
    endfunction

    function bit snow_code(bit [7:0] c);
      return c == csif_pkg::CODE_ICE_A || c == csif_pkg::CODE_ICE_B ||
             c == csif_pkg::CODE_FILLED || (c > 25 && c < 102);
    endfunction

    function void restart();
      left_px  = '0;
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      draining = 1'b0;
    endfunction

    // Any register write also restarts the stream
    function void write_reg(csif_pkg::reg_idx_e idx, bit [csif_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        csif_pkg::REG_GRID_WIDTH:  grid_w = val[10:0];
        csif_pkg::REG_GRID_HEIGHT: grid_h = val[12:0];
        default: ;
      endcase
      settings++;
      restart();
    endfunction

    // Settle the pixel at the output position and queue it; true on frame end
    function bit fill_next(bit has_down, bit [7:0] down);
      int unsigned w, h, c;
      bit          near_ice;
      out_beat_t   r;
      w = grid_cols();
      h = grid_rows();
      c = out_col;
      if (c >= w) c = w - 1;
      near_ice = (out_row > 0 && snow_code(upper_row[c])) ||
                 (c > 0 && snow_code(left_px)) ||
                 (c + 1 < w && snow_code(middle_row[c + 1])) ||
                 (has_down && snow_code(down));
      r.filled = (middle_row[c] == csif_pkg::CODE_COAST) && near_ice;
      r.code   = r.filled ? csif_pkg::CODE_FILLED : middle_row[c];
      r.last   = (out_row + 1 >= h) && (c + 1 >= w);
      upper_row[c] = r.code;
      left_px      = r.code;
      expected_q.push_back(r);
      if (r.filled) fills++;
      out_col = c + 1;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
      return r.last;
    endfunction

    // Note an accepted input beat; returns 0 when the unit ignores it
    function bit take_request(csif_pkg::req_type_e req, bit [7:0] px);
      int unsigned w, h, c;
      w = grid_cols();
      h = grid_rows();
      if (req == csif_pkg::REQ_DRAIN) begin
        if (!draining) begin
          ignored_beats++;
          return 1'b0;
        end
        drain_beats++;
        if (fill_next(1'b0, 8'd0)) begin
          frames++;
          restart();
        end
        return 1'b1;
      end
      if (draining) begin
        ignored_beats++;
        return 1'b0;
      end
      pixel_beats++;
      c = in_col;
      if (c >= w) c = w - 1;
      if (in_row > 0) void'(fill_next(1'b1, px));
      middle_row[c] = px;
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        // Last row in: switch to draining
        if (in_row >= h) begin
          in_row   = h - 1;
          draining = 1'b1;
          out_row  = h - 1;
          out_col  = 0;
        end
      end
      return 1'b1;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Compare an output beat with the oldest prediction
    function void check_output(logic [7:0] code, logic filled, logic last);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected output beat: pixel %0d filled %b last %b",
                             code, filled, last));
        return;
      end
      want = expected_q.pop_front();
      out_beats++;
      if (code !== want.code || filled !== want.filled || last !== want.last) begin
        note_error($sformatf({"output beat %0d: expected pixel %0d filled %b last %b, ",
                              "got pixel %0d filled %b last %b"}, out_beats, want.code,
                             want.filled, want.last, code, filled, last));
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;   // [7:0] pixel_in
  logic                            s_axis_tuser;   // [0] req_type
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [7:0]                      m_axis_tdata;   // [7:0] pixel_out
  logic                            m_axis_tuser;   // [0] was_filled
  logic                            m_axis_tlast;
  logic                            cfg_we_i;
  logic [csif_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [csif_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  fill_scoreboard sb;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    used_beats = 0;
  int unsigned    quiet_cycles = 0;

  coastal_snow_ice_fill_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output side at random
  always @(negedge clk_i) begin
    m_axis_tready <= !(rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct);
  end

  // Check every output beat as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Stream stuck for %0d cycles with %0d output beats outstanding",
               quiet_cycles, sb.expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly coast and snow codes, with the class boundaries now and then
  function automatic logic [7:0] rand_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return csif_pkg::CODE_COAST;
      4: begin
        case ($urandom_range(0, 2))
          0:       return csif_pkg::CODE_ICE_A;
          1:       return csif_pkg::CODE_ICE_B;
          default: return csif_pkg::CODE_FILLED;
        endcase
      end
      5, 6: return 8'($urandom_range(26, 101));
      7: begin
        case ($urandom_range(0, 5))
          0:       return 8'd25;
          1:       return 8'd26;
          2:       return 8'd101;
          3:       return 8'd102;
          4:       return 8'd0;
          default: return 8'd255;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one beat after a random gap and wait until it is taken
  task automatic send_beat(csif_pkg::req_type_e req, logic [7:0] px);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    if (sb.take_request(req, px)) used_beats++;
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Write both grid registers once the unit has gone quiet
  task automatic set_grid(int unsigned w, int unsigned h);
    hold_input();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= csif_pkg::REG_GRID_WIDTH;
    cfg_wdata_i <= csif_pkg::CFG_DATA_W'(w);
    sb.write_reg(csif_pkg::REG_GRID_WIDTH, csif_pkg::CFG_DATA_W'(w));
    @(negedge clk_i);
    cfg_idx_i   <= csif_pkg::REG_GRID_HEIGHT;
    cfg_wdata_i <= csif_pkg::CFG_DATA_W'(h);
    sb.write_reg(csif_pkg::REG_GRID_HEIGHT, csif_pkg::CFG_DATA_W'(h));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One frame of pixels then one row of drains, cut short at beat 'cut'.
  // Sprinkle beats the unit should ignore: drains while filling, pixels while draining.
  task automatic send_frame(int unsigned w, int unsigned h, int unsigned cut);
    int unsigned total;
    total = w * h + w;
    for (int unsigned i = 0; i < total && i < cut; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_beat(i < w * h ? csif_pkg::REQ_DRAIN : csif_pkg::REQ_PIXEL, rand_code());
      end
      send_beat(i < w * h ? csif_pkg::REQ_PIXEL : csif_pkg::REQ_DRAIN, rand_code());
    end
  endtask

  // Small random grid with one to three frames, the last sometimes broken off
  task automatic run_phase();
    int unsigned w, h, cols, rows, nframes;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 5);
    set_grid(w, h);
    cols    = (w == 0) ? 1 : w;
    rows    = (h == 0) ? 1 : h;
    nframes = $urandom_range(1, 3);
    for (int unsigned f = 0; f < nframes; f++) begin
      if (f == nframes - 1 && $urandom_range(0, 7) == 0) begin
        send_frame(cols, rows, $urandom_range(0, cols * rows + cols - 1));
      end else begin
        send_frame(cols, rows, cols * rows + cols);
      end
    end
  endtask

  // Start of a frame at the register extremes, clamped values included
  task automatic run_wide_frame(int unsigned which);
    case (which)
      0: begin
        set_grid(2047, 0);
        send_frame(csif_pkg::MAX_WIDTH, 1, WIDE_BEATS);
      end
      1: begin
        set_grid(csif_pkg::MAX_WIDTH, 2);
        send_frame(csif_pkg::MAX_WIDTH, 2, WIDE_BEATS);
      end
      default: begin
        set_grid(0, 8191);
        send_frame(1, csif_pkg::MAX_HEIGHT, WIDE_BEATS);
      end
    endcase
  endtask

  initial begin
    int unsigned target;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = csif_pkg::REG_GRID_WIDTH;
    cfg_wdata_i   = '0;
    tx_idle_pct   = 32;
    rx_idle_pct   = 64;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame: fills seen through raw down, processed left and processed up
    set_grid(3, 3);
    send_beat(csif_pkg::REQ_DRAIN, 8'hff);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_PIXEL, 8'd25);
    send_beat(csif_pkg::REQ_PIXEL, 8'd102);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_ICE_A);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_ICE_B);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_FILLED);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);
    send_beat(csif_pkg::REQ_PIXEL, 8'd26);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);
    send_beat(csif_pkg::REQ_DRAIN, 8'd101);
    // 2x2 frame of coast with no snow about
    set_grid(2, 2);
    send_beat(csif_pkg::REQ_PIXEL, 8'd255);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_PIXEL, 8'd0);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);
    // Zero width and height act as a single pixel
    set_grid(0, 0);
    send_beat(csif_pkg::REQ_PIXEL, csif_pkg::CODE_COAST);
    send_beat(csif_pkg::REQ_DRAIN, 8'd0);

    // Random phases under three idling regimes
    for (int unsigned m = 0; m < 3; m++) begin
      tx_idle_pct = (m == 0) ? 32 : (m == 1) ? 64 : 0;
      rx_idle_pct = (m == 0) ? 64 : (m == 1) ? 32 : 0;
      run_wide_frame(m);
      target = used_beats + RANDOM_BEATS / 3;
      while (used_beats < target) run_phase();
    end

    // Let the last row drain out
    hold_input();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixel and %0d drain beats (%0d ignored) over %0d register writes.",
             sb.pixel_beats, sb.drain_beats, sb.ignored_beats, sb.settings);
    $display("Checked %0d output beats in %0d whole frames, %0d coast pixels filled.",
             sb.out_beats, sb.frames, sb.fills);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
